FILE: hdl/i2cms_pkg.sv
// Shared types, codes and reset values for the I2C master byte sequencer.
package i2cms_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_START_FAIL  = 2'd1;
   localparam logic [1:0] ST_ACK_TIMEOUT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_PHASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_PHASE  = 2'd2;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
   localparam logic [7:0] WRITE_PHASE_RESET = 8'd1;
   localparam logic [7:0] READ_PHASE_RESET  = 8'd2;

   typedef enum logic [15:0] {
      PH_IDLE   = 16'h0001,
      PH_ST_HI  = 16'h0002,
      PH_ST_LO  = 16'h0004,
      PH_SP_LO  = 16'h0008,
      PH_SP_SCL = 16'h0010,
      PH_SP_HI  = 16'h0020,
      PH_W_SET  = 16'h0040,
      PH_W_HI   = 16'h0080,
      PH_W_LO   = 16'h0100,
      PH_A_SET  = 16'h0200,
      PH_A_HI   = 16'h0400,
      PH_A_POLL = 16'h0800,
      PH_R_LO   = 16'h1000,
      PH_R_HI   = 16'h2000,
      PH_K_SET  = 16'h4000,
      PH_K_HI   = 16'h8000
   } phase_type;

endpackage

FILE: hdl/i2c_master_byte_sequencer.sv
// Top level of the I2C master byte sequencer: tick state machine and result skid buffer.
//
//  channel  direction  fields
//  req      in         tuser: op; tdata: tx_byte, send_ack, sda_in
//  rsp      out        tdata: scl_level, sda_pull_low, busy_res, done_res, status, rx_byte
//  csr      in         csr_we, csr_index, csr_wdata (write only)
//
// Each request beat is one bus tick and yields exactly one response beat.
// The tick is evaluated combinationally from the state registers into the response register,
// so one beat is taken every cycle while the skid entry is empty.
// A one-entry skid stage holds a result while the response side stalls.
// Reset is synchronous and returns the bus drive to released and the registers to defaults.
module i2c_master_byte_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
   input  logic [i2cms_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[2:0]
   input  logic [i2cms_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3], status[5:4], rx_byte[13:6]
   output logic [i2cms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [i2cms_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import i2cms_pkg::*;

   logic [7:0] ack_timeout_ff;
   logic [7:0] write_phase_ff;
   logic [7:0] read_phase_ff;

   phase_type  phase_ff, phase_in;
   logic [2:0] command_ff, command_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] wait_ff, wait_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       drive_scl_ff, drive_scl_in;
   logic       drive_sda_ff, drive_sda_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic [RSP_DATA_W-1:0] rsp_ff, skid_ff;
   logic                  rsp_valid_ff, skid_valid_ff;

   logic [2:0] op;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_level;
   logic       req_accept;
   logic       done;
   logic [1:0] status;
   logic [7:0] wticks;
   logic [7:0] rticks;
   logic [RSP_DATA_W-1:0] result;

   assign op        = req_tuser;
   assign tx_byte   = req_tdata[7:0];
   assign send_ack  = req_tdata[8];
   assign sda_level = req_tdata[9];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign wticks = (write_phase_ff == 8'd0) ? 8'd1 : write_phase_ff;
   assign rticks = (read_phase_ff == 8'd0) ? 8'd1 : read_phase_ff;

   always_comb begin
      phase_in      = phase_ff;
      command_in    = command_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      wait_in       = wait_ff;
      ack_choice_in = ack_choice_ff;
      drive_scl_in  = drive_scl_ff;
      drive_sda_in  = drive_sda_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      status        = ST_OK;

      if (phase_ff == PH_IDLE) begin
         case (op) inside
            OP_START, OP_STOP, OP_WRITE, OP_READ: command_in = op;
            default: ;
         endcase
         unique case (op)
            OP_START: begin
               drive_sda_in = 1'b1;
               if (!sda_level) begin
                  done   = 1'b1;
                  status = ST_START_FAIL;
               end else begin
                  drive_scl_in = 1'b1;
                  phase_in     = PH_ST_HI;
                  tick_in      = wticks;
               end
            end
            OP_STOP: begin
               drive_scl_in = 1'b0;
               drive_sda_in = 1'b0;
               phase_in     = PH_SP_LO;
               tick_in      = wticks;
            end
            OP_WRITE: begin
               shift_in     = tx_byte;
               bit_count_in = 4'd0;
               drive_scl_in = 1'b0;
               drive_sda_in = tx_byte[7];
               phase_in     = PH_W_SET;
               tick_in      = wticks;
            end
            OP_READ: begin
               ack_choice_in = send_ack;
               shift_in      = 8'd0;
               bit_count_in  = 4'd0;
               drive_sda_in  = 1'b1;
               drive_scl_in  = 1'b0;
               phase_in      = PH_R_LO;
               tick_in       = rticks;
            end
            default: ;
         endcase
      end else if (phase_ff == PH_A_POLL) begin
         if (!sda_level) begin
            drive_scl_in = 1'b0;
            phase_in     = PH_IDLE;
            done         = 1'b1;
         end else if (wait_ff >= ack_timeout_ff) begin
            drive_scl_in = 1'b0;
            drive_sda_in = 1'b0;
            phase_in     = PH_SP_LO;
            tick_in      = wticks;
         end else begin
            wait_in = wait_ff + 8'd1;
         end
      end else if (tick_ff > 8'd1) begin
         tick_in = tick_ff - 8'd1;
      end else begin
         tick_in = 8'd0;
         unique case (phase_ff)
            PH_ST_HI: begin
               drive_sda_in = 1'b0;
               if (sda_level) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
                  status   = ST_START_FAIL;
               end else begin
                  phase_in = PH_ST_LO;
                  tick_in  = wticks;
               end
            end
            PH_ST_LO: begin
               drive_scl_in = 1'b0;
               phase_in     = PH_IDLE;
               done         = 1'b1;
            end
            PH_SP_LO: begin
               drive_scl_in = 1'b1;
               phase_in     = PH_SP_SCL;
               tick_in      = wticks;
            end
            PH_SP_SCL: begin
               drive_sda_in = 1'b1;
               phase_in     = PH_SP_HI;
               tick_in      = wticks;
            end
            PH_SP_HI: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
               status   = (command_ff == OP_WRITE) ? ST_ACK_TIMEOUT : ST_OK;
            end
            PH_W_SET: begin
               drive_scl_in = 1'b1;
               phase_in     = PH_W_HI;
               tick_in      = wticks;
            end
            PH_W_HI: begin
               drive_scl_in = 1'b0;
               phase_in     = PH_W_LO;
               tick_in      = wticks;
            end
            PH_W_LO: begin
               bit_count_in = bit_count_ff + 4'd1;
               if (bit_count_in < 4'd8) begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  drive_sda_in = shift_ff[6];
                  phase_in     = PH_W_SET;
               end else begin
                  drive_sda_in = 1'b1;
                  phase_in     = PH_A_SET;
               end
               tick_in = wticks;
            end
            PH_A_SET: begin
               drive_scl_in = 1'b1;
               phase_in     = PH_A_HI;
               tick_in      = wticks;
            end
            PH_A_HI: begin
               wait_in  = 8'd0;
               phase_in = PH_A_POLL;
            end
            PH_R_LO: begin
               drive_scl_in = 1'b1;
               shift_in     = {shift_ff[6:0], sda_level};
               phase_in     = PH_R_HI;
               tick_in      = rticks;
            end
            PH_R_HI: begin
               bit_count_in = bit_count_ff + 4'd1;
               drive_scl_in = 1'b0;
               if (bit_count_in < 4'd8) begin
                  phase_in = PH_R_LO;
                  tick_in  = rticks;
               end else begin
                  rx_hold_in   = shift_ff;
                  drive_sda_in = !ack_choice_ff;
                  phase_in     = PH_K_SET;
                  tick_in      = wticks;
               end
            end
            PH_K_SET: begin
               drive_scl_in = 1'b1;
               phase_in     = PH_K_HI;
               tick_in      = wticks;
            end
            PH_K_HI: begin
               drive_scl_in = 1'b0;
               phase_in     = PH_IDLE;
               done         = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign result = {2'b00, rx_hold_in, status, done, (phase_in != PH_IDLE),
                    !drive_sda_in, drive_scl_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         write_phase_ff <= WRITE_PHASE_RESET;
         read_phase_ff  <= READ_PHASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            CSR_WRITE_PHASE: write_phase_ff <= csr_wdata;
            CSR_READ_PHASE:  read_phase_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         command_ff    <= OP_NONE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         tick_ff       <= 8'd0;
         wait_ff       <= 8'd0;
         ack_choice_ff <= 1'b0;
         drive_scl_ff  <= 1'b1;
         drive_sda_ff  <= 1'b1;
         rx_hold_ff    <= 8'd0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         command_ff    <= command_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         wait_ff       <= wait_in;
         ack_choice_ff <= ack_choice_in;
         drive_scl_ff  <= drive_scl_in;
         drive_sda_ff  <= drive_sda_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   // The skid entry fills only when a beat arrives while the response register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (req_accept) begin
            rsp_ff <= result;
         end
      end else if (req_accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

FILE: verif/i2cms_bus_checker.sv
`timescale 1ns / 1ps
// Checker that mirrors the I2C sequencer tick by tick and compares every response beat.
module i2cms_bus_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
   input  logic [i2cms_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[2:0]
   input  logic [i2cms_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3], status[5:4], rx_byte[13:6]
   input  logic [i2cms_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [i2cms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cms_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                pending,
   output int                                errors,
   output int                                checked
);
   import i2cms_pkg::*;

   typedef struct packed {
      logic [7:0] rx;
      logic [1:0] status;
      logic       done;
      logic       busy;
      logic       sda_low;
      logic       scl;
   } bus_drive_type;

   logic [7:0] ack_limit;
   logic [7:0] wr_ticks;
   logic [7:0] rd_ticks;

   phase_type  bus_phase;
   logic [2:0] cur_cmd;
   logic [3:0] bit_cnt;
   logic [7:0] shifter;
   logic [7:0] tick_cnt;
   logic [7:0] poll_cnt;
   logic       ack_pick;
   logic       scl_drv;
   logic       sda_drv;
   logic [7:0] rx_last;

   bus_drive_type drive_q[$];

   initial begin
      errors = 0;
      checked = 0;
      pending = 0;
   end

   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   task automatic enter_phase(input phase_type ph, input logic [7:0] n);
      bus_phase = ph;
      tick_cnt = n;
   endtask

   task automatic begin_stop_seq();
      scl_drv = 1'b0;
      sda_drv = 1'b0;
      enter_phase(PH_SP_LO, at_least_one(wr_ticks));
   endtask

   task automatic advance_bus(input logic [2:0] op, input logic [7:0] txb, input logic ackin,
                              input logic sda, output bus_drive_type d);
      logic       fin;
      logic [1:0] st;
      logic [7:0] wt;
      logic [7:0] rt;
      fin = 1'b0;
      st = ST_OK;
      wt = at_least_one(wr_ticks);
      rt = at_least_one(rd_ticks);
      if (bus_phase == PH_IDLE) begin
         if (op >= OP_START && op <= OP_READ) cur_cmd = op;
         case (op)
            OP_START: begin
               sda_drv = 1'b1;
               if (!sda) begin
                  fin = 1'b1;
                  st = ST_START_FAIL;
               end else begin
                  scl_drv = 1'b1;
                  enter_phase(PH_ST_HI, wt);
               end
            end
            OP_STOP: begin_stop_seq();
            OP_WRITE: begin
               shifter = txb;
               bit_cnt = 4'd0;
               scl_drv = 1'b0;
               sda_drv = txb[7];
               enter_phase(PH_W_SET, wt);
            end
            OP_READ: begin
               ack_pick = ackin;
               shifter = 8'd0;
               bit_cnt = 4'd0;
               sda_drv = 1'b1;
               scl_drv = 1'b0;
               enter_phase(PH_R_LO, rt);
            end
            default: ;
         endcase
      end else if (bus_phase == PH_A_POLL) begin
         if (!sda) begin
            scl_drv = 1'b0;
            bus_phase = PH_IDLE;
            fin = 1'b1;
         end else if (poll_cnt >= ack_limit) begin
            begin_stop_seq();
         end else begin
            poll_cnt++;
         end
      end else if (tick_cnt > 8'd1) begin
         tick_cnt--;
      end else begin
         tick_cnt = 8'd0;
         case (bus_phase)
            PH_ST_HI: begin
               sda_drv = 1'b0;
               if (sda) begin
                  bus_phase = PH_IDLE;
                  fin = 1'b1;
                  st = ST_START_FAIL;
               end else begin
                  enter_phase(PH_ST_LO, wt);
               end
            end
            PH_ST_LO: begin
               scl_drv = 1'b0;
               bus_phase = PH_IDLE;
               fin = 1'b1;
            end
            PH_SP_LO: begin
               scl_drv = 1'b1;
               enter_phase(PH_SP_SCL, wt);
            end
            PH_SP_SCL: begin
               sda_drv = 1'b1;
               enter_phase(PH_SP_HI, wt);
            end
            PH_SP_HI: begin
               bus_phase = PH_IDLE;
               fin = 1'b1;
               st = (cur_cmd == OP_WRITE) ? ST_ACK_TIMEOUT : ST_OK;
            end
            PH_W_SET: begin
               scl_drv = 1'b1;
               enter_phase(PH_W_HI, wt);
            end
            PH_W_HI: begin
               scl_drv = 1'b0;
               enter_phase(PH_W_LO, wt);
            end
            PH_W_LO: begin
               bit_cnt++;
               if (bit_cnt < 4'd8) begin
                  shifter = shifter << 1;
                  sda_drv = shifter[7];
                  enter_phase(PH_W_SET, wt);
               end else begin
                  sda_drv = 1'b1;
                  enter_phase(PH_A_SET, wt);
               end
            end
            PH_A_SET: begin
               scl_drv = 1'b1;
               enter_phase(PH_A_HI, wt);
            end
            PH_A_HI: begin
               poll_cnt = 8'd0;
               bus_phase = PH_A_POLL;
            end
            PH_R_LO: begin
               scl_drv = 1'b1;
               shifter = {shifter[6:0], sda};
               enter_phase(PH_R_HI, rt);
            end
            PH_R_HI: begin
               bit_cnt++;
               scl_drv = 1'b0;
               if (bit_cnt < 4'd8) begin
                  enter_phase(PH_R_LO, rt);
               end else begin
                  rx_last = shifter;
                  sda_drv = !ack_pick;
                  enter_phase(PH_K_SET, wt);
               end
            end
            PH_K_SET: begin
               scl_drv = 1'b1;
               enter_phase(PH_K_HI, wt);
            end
            PH_K_HI: begin
               scl_drv = 1'b0;
               bus_phase = PH_IDLE;
               fin = 1'b1;
            end
            default: ;
         endcase
      end
      d.scl = scl_drv;
      d.sda_low = !sda_drv;
      d.busy = (bus_phase != PH_IDLE);
      d.done = fin;
      d.status = st;
      d.rx = rx_last;
   endtask

   task automatic compare_field(input string what, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      bus_drive_type want;
      bus_drive_type next_drive;
      if (reset) begin
         ack_limit = ACK_TIMEOUT_RESET;
         wr_ticks = WRITE_PHASE_RESET;
         rd_ticks = READ_PHASE_RESET;
         bus_phase = PH_IDLE;
         cur_cmd = OP_NONE;
         bit_cnt = 4'd0;
         shifter = 8'd0;
         tick_cnt = 8'd0;
         poll_cnt = 8'd0;
         ack_pick = 1'b0;
         scl_drv = 1'b1;
         sda_drv = 1'b1;
         rx_last = 8'd0;
         drive_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACK_TIMEOUT: ack_limit = csr_wdata;
               CSR_WRITE_PHASE: wr_ticks = csr_wdata;
               CSR_READ_PHASE:  rd_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               errors++;
               $display("%0t ns: response beat with nothing expected, actual %h", $time,
                        rsp_tdata);
            end else begin
               want = drive_q.pop_front();
               compare_field("scl_level", int'(want.scl), int'(rsp_tdata[0]));
               compare_field("sda_pull_low", int'(want.sda_low), int'(rsp_tdata[1]));
               compare_field("busy", int'(want.busy), int'(rsp_tdata[2]));
               compare_field("done", int'(want.done), int'(rsp_tdata[3]));
               compare_field("status", int'(want.status), int'(rsp_tdata[5:4]));
               compare_field("rx_byte", int'(want.rx), int'(rsp_tdata[13:6]));
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            advance_bus(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9], next_drive);
            drive_q.push_back(next_drive);
         end
      end
      pending = drive_q.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the I2C master byte sequencer: clock, reset, stimulus and verdict.
module tb_top;
   import i2cms_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 200;
   localparam int PHASES = 4;
   localparam int COMMANDS_PER_PHASE = 5;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = OP_NONE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ACK_TIMEOUT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int pending;
   int errors;
   int checked;

   int send_idle = 0;
   int recv_stall = 0;
   int hold_go = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int beats_sent = 0;
   int cmds_sent = 0;
   int settings_used = 0;

   logic [7:0] cfg_at = ACK_TIMEOUT_RESET;
   logic [7:0] cfg_wt = WRITE_PHASE_RESET;
   logic [7:0] cfg_rt = READ_PHASE_RESET;

   i2c_master_byte_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   i2cms_bus_checker bus_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > recv_stall);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic [2:0] op, input logic [7:0] txb, input logic ackin,
                            input logic sda);
      while (send_idle > 0 && $urandom_range(1, 100) <= send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, sda, ackin, txb};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      @(negedge clock);
   endtask

   // Ticks while a command runs; some carry a stray command that must be ignored.
   task automatic busy_ticks(input int n, input int sda_kind);
      logic [2:0] op;
      logic [7:0] txb;
      logic       lvl;
      for (int i = 0; i < n; i++) begin
         op = OP_NONE;
         if ($urandom_range(0, 9) == 0) op = 3'($urandom_range(0, 7));
         txb = 8'($urandom);
         lvl = 1'($urandom);
         if (sda_kind == 1) lvl = 1'b1;
         if (sda_kind == 2) lvl = 1'b0;
         send_beat(op, txb, 1'($urandom), lvl);
      end
   endtask

   // For a start, how picks normal, busy bus or SDA not following; for a write it is
   // the number of high ACK polls; for a read it picks random, all-high or all-low data.
   task automatic issue(input logic [2:0] op, input logic [7:0] txb, input logic ackin,
                        input int how);
      int wt;
      int rt;
      wt = (cfg_wt == 8'd0) ? 1 : int'(cfg_wt);
      rt = (cfg_rt == 8'd0) ? 1 : int'(cfg_rt);
      cmds_sent++;
      case (op)
         OP_START: begin
            send_beat(OP_START, txb, ackin, how != 1);
            if (how == 0) busy_ticks(2 * wt, 2);
            else if (how == 2) busy_ticks(wt, 1);
         end
         OP_STOP: begin
            send_beat(OP_STOP, txb, ackin, 1'($urandom));
            busy_ticks(3 * wt, 0);
         end
         OP_WRITE: begin
            send_beat(OP_WRITE, txb, ackin, 1'($urandom));
            busy_ticks(26 * wt, 0);
            if (how > int'(cfg_at)) begin
               busy_ticks(int'(cfg_at) + 1, 1);
               busy_ticks(3 * wt, 0);
            end else begin
               busy_ticks(how, 1);
               busy_ticks(1, 2);
            end
         end
         OP_READ: begin
            send_beat(OP_READ, txb, ackin, 1'($urandom));
            busy_ticks(16 * rt, how);
            busy_ticks(2 * wt, 0);
         end
         default: send_beat(op, txb, ackin, 1'($urandom));
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_cfg(input logic [7:0] at, input logic [7:0] wt, input logic [7:0] rt);
      drain();
      repeat (2) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ACK_TIMEOUT;
      csr_wdata <= at;
      @(negedge clock);
      csr_index <= CSR_WRITE_PHASE;
      csr_wdata <= wt;
      @(negedge clock);
      csr_index <= CSR_READ_PHASE;
      csr_wdata <= rt;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_at = at;
      cfg_wt = wt;
      cfg_rt = rt;
      settings_used++;
   endtask

   task automatic random_command();
      int r;
      int v;
      int k;
      logic [2:0] op;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         v = $urandom_range(0, 9);
         issue(OP_START, 8'($urandom), 1'($urandom), (v == 0) ? 1 : (v == 1) ? 2 : 0);
      end else if (r < 55) begin
         v = $urandom_range(0, 9);
         if (v < 6) k = $urandom_range(0, (cfg_at < 8'd3) ? int'(cfg_at) : 3);
         else if (v < 8) k = int'(cfg_at);
         else k = int'(cfg_at) + 1;
         issue(OP_WRITE, 8'($urandom), 1'($urandom), k);
      end else if (r < 80) begin
         v = $urandom_range(0, 9);
         issue(OP_READ, 8'($urandom), 1'($urandom), (v < 8) ? 0 : v - 7);
      end else if (r < 95) begin
         issue(OP_STOP, 8'($urandom), 1'($urandom), 0);
      end else begin
         repeat ($urandom_range(1, 4)) begin
            op = 3'($urandom_range(0, 7));
            send_beat(op, 8'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      int m;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, first at the reset settings.
      issue(OP_NONE, 8'h00, 1'b0, 0);
      for (int c = OP_READ + 1; c < 8; c++) issue(3'(c), 8'hFF, 1'b1, 0);
      issue(OP_START, 8'h00, 1'b0, 0);
      issue(OP_WRITE, 8'h00, 1'b0, 0);
      issue(OP_WRITE, 8'hFF, 1'b1, 1);
      issue(OP_READ, 8'h00, 1'b1, 1);
      issue(OP_READ, 8'hFF, 1'b0, 2);
      issue(OP_STOP, 8'h00, 1'b0, 0);
      issue(OP_START, 8'h00, 1'b0, 1);
      issue(OP_START, 8'h00, 1'b0, 2);
      issue(OP_STOP, 8'h00, 1'b0, 0);
      issue(OP_WRITE, 8'hA5, 1'b0, int'(cfg_at) + 1);
      issue(OP_READ, 8'h00, 1'b1, 0);

      write_cfg(8'd0, 8'd0, 8'd0);
      issue(OP_START, 8'h00, 1'b0, 0);
      issue(OP_WRITE, 8'h3C, 1'b0, 1);
      issue(OP_WRITE, 8'hC3, 1'b0, 0);
      issue(OP_READ, 8'h00, 1'b0, 0);
      issue(OP_STOP, 8'h00, 1'b0, 0);

      write_cfg(8'd255, 8'd6, 8'd5);
      issue(OP_START, 8'h00, 1'b0, 0);
      issue(OP_READ, 8'h00, 1'b1, 0);
      issue(OP_STOP, 8'h00, 1'b0, 0);

      write_cfg(8'd3, 8'd1, 8'd1);
      issue(OP_WRITE, 8'h81, 1'b0, 3);
      issue(OP_WRITE, 8'h7E, 1'b0, 4);

      // Random part: each phase has its own register setting and idle pattern.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) write_cfg(8'd0, 8'd0, 8'd0);
         else if (p == PHASES - 1) write_cfg(8'd255, 8'd1, 8'd1);
         else write_cfg(8'($urandom_range(0, 6)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 3)));
         m = p % 4;
         send_idle = (m == 1) ? 74 : (m == 3) ? 34 : 0;
         recv_stall = (m == 2) ? 74 : (m == 3) ? 34 : 0;
         hold_go++;
         for (int c = 0; c < COMMANDS_PER_PHASE; c++) begin
            if ($urandom_range(0, 49) == 0) drain();
            random_command();
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("Run covered %0d request beats in %0d bus commands over %0d register settings,",
               beats_sent, cmds_sent, settings_used);
      $display("with start, stop, write and read under four idle patterns; %0d beats checked.",
               checked);
      if (errors == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: i2c_master_byte_sequencer.f
hdl/i2cms_pkg.sv
hdl/i2c_master_byte_sequencer.sv
verif/i2cms_bus_checker.sv
verif/tb_top.sv
